>>> rtl/cbs_pkg.sv
// Package for the cubic B-spline surface evaluator: sizes, codes, basis table.
// Used by cbs_weight and the top level of the block.
`default_nettype none
package cbs_pkg;
	localparam int MaxRows = 64;
	localparam int MaxCols = 64;
	localparam int CoordW = 24;
	localparam int RowW = $clog2(MaxRows);
	localparam int ColW = $clog2(MaxCols);
	localparam int AddrW = RowW + ColW;
	localparam int Depth = MaxRows * MaxCols;
	localparam int SizeW = 7;

	typedef enum logic [0:0] {REQ_WRITE = 1'b0, REQ_EVAL = 1'b1} req_t;
	typedef enum logic [0:0] {REG_ROWS = 1'b0, REG_COLS = 1'b1} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_WGT, ST_READ, ST_MAC, ST_DONE
	} state_t;

	// 12 x basis coefficient, [class][point][power]; class is 0..4
	function automatic logic signed [6:0] basis12(input logic [2:0] cls,
			input logic [1:0] pt, input logic [1:0] pw);
		logic signed [6:0] t [0:79];
		begin
			t = '{12,-36,36,-12, 0,36,-54,21, 0,0,18,-11, 0,0,0,2,
				3,-9,9,-3, 7,3,-15,7, 2,6,6,-6, 0,0,0,2,
				2,-6,6,-2, 8,0,-12,6, 2,6,6,-6, 0,0,0,2,
				2,-6,6,-2, 8,0,-12,6, 2,6,6,-7, 0,0,0,3,
				2,-6,6,-2, 7,-3,-15,11, 3,9,9,-21, 0,0,0,12};
			basis12 = t[{cls, pt, pw}];
		end
	endfunction
endpackage
`default_nettype wire

>>> rtl/cbs_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module cbs_ram #(
	parameter int Width = 24,
	parameter int Depth = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output      logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [0:Depth-1];
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

>>> rtl/cbs_weight.sv
// Per-direction span and Q16 basis weight unit: one weight per call, Horner
// form evaluated step by step through one shared multiplier. Uses cbs_pkg.
`default_nettype none
module cbs_weight import cbs_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [16:0]       par,
	input  wire logic [SizeW-1:0]  size,
	input  wire logic [1:0]        pt,
	output      logic              done,
	output      logic [5:0]        span,
	output      logic signed [17:0] weight
);
	// s in Q16 (0..65536); Horner: acc = ((c3*s + c2*2^16)*s + c1*2^32)*s + c0*2^48
	logic [2:0]         step_q;
	logic               busy_q;
	logic [16:0]        s_q;
	logic [5:0]         j_q;
	logic [2:0]         cls_q;
	logic signed [71:0] acc_q;
	logic [22:0]        prod;
	logic [5:0]         n;
	logic [16:0]        p;
	logic [5:0]         jraw;
	logic [16:0]        sraw;
	logic [5:0]         jc;
	logic [2:0]         cls;
	logic signed [6:0]  cf;
	logic signed [71:0] mulr;
	logic signed [71:0] num;
	logic [17:0]        q4;
	logic [36:0]        qm;

	assign n = 6'(size - 7'd3);
	assign p = (par > 17'd65536) ? 17'd65536 : par;
	assign prod = 23'(p) * 23'(n);
	assign jraw = prod[21:16];
	assign sraw = {1'b0, prod[15:0]};
	always_comb begin
		jc = jraw;
		if ({1'b0, prod[22:16]} >= {2'b0, n}) jc = n - 6'd1;
		if (jc == 6'd0) cls = 3'd0;
		else if (jc == 6'd1) cls = 3'd1;
		else if ({1'b0, jc} + 7'd5 < size) cls = 3'd2;
		else if ({1'b0, jc} + 7'd4 < size) cls = 3'd3;
		else cls = 3'd4;
	end

	assign cf = basis12(cls_q, pt, 2'(3 - step_q));
	// acc * s; acc stays below ~2^56 so low 72 bits are exact
	assign mulr = acc_q * $signed({1'b0, s_q});
	assign num = acc_q + 72'sd25769803776;
	// floor(num / (12*2^32)) = floor((num >> 34) / 3); num >= 0 for every weight,
	// and num >> 34 stays below 2^19 where the reciprocal 349526 / 2^20 is exact
	assign q4 = 18'(num >>> 34);
	assign qm = 37'(q4) * 37'd349526;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 3'd0;
				j_q <= jc;
				s_q <= ({1'b0, prod[22:16]} >= {2'b0, n}) ? 17'd65536 : sraw;
				cls_q <= cls;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd0) acc_q <= 72'(cf);
				else if (step_q < 3'd4) acc_q <= mulr + (72'(cf) <<< 16 * step_q);
				else begin
					busy_q <= 1'b0;
					done <= 1'b1;
					span <= j_q;
					weight <= {1'b0, qm[36:20]};
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/cubic_bspline_surface_eval.sv
// Top level of the cubic B-spline surface evaluator: control point stores,
// sequencer, shared multiply-accumulate. Uses cbs_pkg, cbs_ram, cbs_weight.
`default_nettype none
// A write transfer stores one control point. An evaluate runs from its
// transfer to a valid result in these steps: eight basis weights from the
// shared Horner unit, then sixteen store reads, each a slot of read, weight
// product and three multiply-accumulates through one shared multiplier, and
// then the load of the result register. The block takes no input while it
// evaluates or while a result waits in its output register.
module cubic_bspline_surface_eval import cbs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	// tdata: row_index, col_index, coord_x_in, coord_y_in, coord_z_in, u_param, v_param
	input  wire logic [119:0] s_tdata,
	// tuser: req_type
	input  wire logic        s_tuser,
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	// tdata: pos_x, pos_y, pos_z, span_row, span_col
	output      logic [87:0] m_tdata,
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [SizeW-1:0] cfg_data
);
	state_t state_q, state_d;
	logic [SizeW-1:0] rows_q, cols_q, rs, cs;
	logic [16:0] u_q, v_q;
	logic [3:0] wi_q;
	logic [3:0] wn;
	logic signed [17:0] wt_q [0:7];
	logic [5:0] ju_q, jv_q;
	logic [3:0] pi_q;
	logic [2:0] ph_q;
	logic w_start, w_done;
	logic [5:0] w_span;
	logic signed [17:0] w_wt;
	logic signed [47:0] acc_x_q, acc_y_q, acc_z_q;
	logic signed [35:0] pp;
	logic signed [18:0] pw_q;
	logic [CoordW-1:0] rx, ry, rz;
	logic [AddrW-1:0] addr;
	logic we;
	logic signed [43:0] mac;
	logic signed [CoordW-1:0] mopnd;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 7'd4;
			cols_q <= 7'd4;
		end else if (cfg_valid) begin
			if (cfg_index == REG_ROWS) rows_q <= cfg_data;
			else cols_q <= cfg_data;
		end
	end
	assign rs = (rows_q < 7'd4) ? 7'd4 : (rows_q > 7'(MaxRows)) ? 7'(MaxRows) : rows_q;
	assign cs = (cols_q < 7'd4) ? 7'd4 : (cols_q > 7'(MaxCols)) ? 7'(MaxCols) : cols_q;

	assign s_tready = (state_q == ST_IDLE) && !m_tvalid;
	assign we = s_tvalid && s_tready && (s_tuser == REQ_WRITE);
	assign addr = we ? {s_tdata[5:0], s_tdata[11:6]}
		: {6'(ju_q + 6'(pi_q[3:2])), 6'(jv_q + 6'(pi_q[1:0]))};

	cbs_ram #(.Width(CoordW), .Depth(Depth)) u_ram_x (.clk, .we, .addr,
		.wdata(s_tdata[35:12]), .rdata(rx));
	cbs_ram #(.Width(CoordW), .Depth(Depth)) u_ram_y (.clk, .we, .addr,
		.wdata(s_tdata[59:36]), .rdata(ry));
	cbs_ram #(.Width(CoordW), .Depth(Depth)) u_ram_z (.clk, .we, .addr,
		.wdata(s_tdata[83:60]), .rdata(rz));

	// span and parameter are sampled at start, for the weight about to run
	assign wn = (state_q == ST_WGT) ? wi_q + 4'd1 : 4'd0;

	cbs_weight u_wgt (.clk, .arst_n, .start(w_start),
		.par((state_q == ST_IDLE) ? s_tdata[100:84] : (wn[2] ? v_q : u_q)),
		.size(wn[2] ? cs : rs), .pt(wi_q[1:0]),
		.done(w_done), .span(w_span), .weight(w_wt));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid && s_tready && s_tuser == REQ_EVAL) state_d = ST_WGT;
			ST_WGT:  if (w_done && wi_q == 4'd7) state_d = ST_READ;
			ST_READ: state_d = ST_MAC;
			ST_MAC:  if (ph_q == 3'd4) state_d = (pi_q == 4'd15) ? ST_DONE : ST_READ;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		w_start = (state_q == ST_IDLE && state_d == ST_WGT)
			|| (state_q == ST_WGT && w_done && wi_q != 4'd7);
	end

	assign pp = wt_q[{1'b0, pi_q[3:2]}] * wt_q[{1'b1, pi_q[1:0]}];
	always_comb begin
		case (ph_q)
			3'd2: mopnd = rx;
			3'd3: mopnd = ry;
			default: mopnd = rz;
		endcase
	end
	assign mac = pw_q * mopnd;

	function automatic logic [CoordW-1:0] fin(input logic signed [47:0] a);
		logic signed [47:0] r;
		begin
			r = (a + 48'sd32768) >>> 16;
			if (r > 48'sd8388607) fin = 24'h7FFFFF;
			else if (r < -48'sd8388608) fin = 24'h800000;
			else fin = r[CoordW-1:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid <= 1'b0;
			wi_q <= '0;
			pi_q <= '0;
			ph_q <= '0;
		end else begin
			state_q <= state_d;
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: if (state_d == ST_WGT) begin
					u_q <= s_tdata[100:84];
					v_q <= s_tdata[117:101];
					wi_q <= 4'd0;
				end
				ST_WGT: if (w_done) begin
					wt_q[wi_q[2:0]] <= w_wt;
					if (wi_q == 4'd0) ju_q <= w_span;
					if (wi_q == 4'd4) jv_q <= w_span;
					wi_q <= wi_q + 4'd1;
					acc_x_q <= '0; acc_y_q <= '0; acc_z_q <= '0;
					pi_q <= '0;
				end
				ST_READ: ph_q <= 3'd0;
				ST_MAC: begin
					ph_q <= ph_q + 3'd1;
					if (ph_q == 3'd1) pw_q <= 19'((pp + 36'sd32768) >>> 16);
					if (ph_q == 3'd2) acc_x_q <= acc_x_q + 48'(mac);
					if (ph_q == 3'd3) acc_y_q <= acc_y_q + 48'(mac);
					if (ph_q == 3'd4) begin
						acc_z_q <= acc_z_q + 48'(mac);
						pi_q <= pi_q + 4'd1;
					end
				end
				ST_DONE: begin
					m_tvalid <= 1'b1;
					m_tdata <= {4'd0, jv_q, ju_q, fin(acc_z_q), fin(acc_y_q),
						fin(acc_x_q)};
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> bench/cbs_surface_checker.sv
// Checker for the cubic B-spline surface evaluator: follows transfers on the
// input, output and register channels, predicts each surface point and compares.
// Depends on cbs_pkg for the request and register codes.
`timescale 1ns / 100ps
module cbs_surface_checker import cbs_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [119:0] s_tdata,
	input  wire logic         s_tuser,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [87:0]  m_tdata,
	input  wire logic         cfg_valid,
	input  wire logic         cfg_ready,
	input  wire logic [0:0]   cfg_index,
	input  wire logic [6:0]   cfg_data,
	output int                errors,
	output int                pending
);
	typedef struct {
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic signed [23:0] pz;
		logic [5:0]         row0;
		logic [5:0]         col0;
	} surf_point_t;

	// 12 x basis coefficient per class, point, power
	localparam longint BASIS [0:79] = '{12,-36,36,-12, 0,36,-54,21, 0,0,18,-11, 0,0,0,2,
		3,-9,9,-3, 7,3,-15,7, 2,6,6,-6, 0,0,0,2,
		2,-6,6,-2, 8,0,-12,6, 2,6,6,-6, 0,0,0,2,
		2,-6,6,-2, 8,0,-12,6, 2,6,6,-7, 0,0,0,3,
		2,-6,6,-2, 7,-3,-15,11, 3,9,9,-21, 0,0,0,12};

	logic signed [23:0] grid_x [0:4095];
	logic signed [23:0] grid_y [0:4095];
	logic signed [23:0] grid_z [0:4095];
	logic [6:0] rows_reg, cols_reg;
	surf_point_t points_due [$];

	function automatic longint fdiv(longint n, longint d);
		if (n >= 0)
			return n / d;
		return -((-n + d - 1) / d);
	endfunction

	function automatic int eff_size(logic [6:0] r);
		if (r < 4)
			return 4;
		if (r > 64)
			return 64;
		return int'(r);
	endfunction

	// span start and Q16 weights for one direction
	function automatic int span_weights(logic [16:0] par, int size, output longint w [4]);
		int n, cls, j;
		longint p, prod, s, big;
		n = size - 3;
		p = (par > 17'd65536) ? 65536 : longint'(par);
		prod = p * n;
		j = int'(prod >> 16);
		s = prod & 64'hFFFF;
		if (j >= n) begin
			j = n - 1;
			s = 65536;
		end
		if (j == 0) cls = 0;
		else if (j == 1) cls = 1;
		else if (j < size - 5) cls = 2;
		else if (j < size - 4) cls = 3;
		else cls = 4;
		for (int i = 0; i < 4; i++) begin
			big = BASIS[cls*16+i*4] * (64'sd1 <<< 48) + BASIS[cls*16+i*4+1] * s * (64'sd1 <<< 32)
				+ BASIS[cls*16+i*4+2] * (s * s) * 65536 + BASIS[cls*16+i*4+3] * (s * s * s);
			w[i] = fdiv(big + 6 * (64'sd1 <<< 32), 12 * (64'sd1 <<< 32));
		end
		return j;
	endfunction

	function automatic logic signed [23:0] round_sat(longint acc);
		longint r;
		r = fdiv(acc + 32768, 65536);
		if (r > 8388607) r = 8388607;
		if (r < -8388608) r = -8388608;
		return 24'(r);
	endfunction

	function automatic surf_point_t eval_point(logic [16:0] u, logic [16:0] v);
		surf_point_t pt;
		longint wu [4], wv [4];
		longint ax, ay, az, pw;
		int ju, jv, idx;
		ju = span_weights(u, eff_size(rows_reg), wu);
		jv = span_weights(v, eff_size(cols_reg), wv);
		ax = 0; ay = 0; az = 0;
		for (int i = 0; i < 4; i++)
			for (int k = 0; k < 4; k++) begin
				pw = fdiv(wu[i] * wv[k] + 32768, 65536);
				idx = (ju + i) * 64 + jv + k;
				ax += pw * longint'(grid_x[idx]);
				ay += pw * longint'(grid_y[idx]);
				az += pw * longint'(grid_z[idx]);
			end
		pt.px = round_sat(ax);
		pt.py = round_sat(ay);
		pt.pz = round_sat(az);
		pt.row0 = 6'(ju);
		pt.col0 = 6'(jv);
		return pt;
	endfunction

	initial begin
		for (int i = 0; i < 4096; i++) begin
			grid_x[i] = '0;
			grid_y[i] = '0;
			grid_z[i] = '0;
		end
		rows_reg = 7'd4;
		cols_reg = 7'd4;
		errors = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		surf_point_t want;
		int idx;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ROWS)
					rows_reg = cfg_data;
				else
					cols_reg = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == REQ_WRITE) begin
					idx = int'(s_tdata[5:0]) * 64 + int'(s_tdata[11:6]);
					grid_x[idx] = s_tdata[35:12];
					grid_y[idx] = s_tdata[59:36];
					grid_z[idx] = s_tdata[83:60];
				end else begin
					points_due = {points_due, eval_point(s_tdata[100:84], s_tdata[117:101])};
				end
			end
			if (m_tvalid && m_tready) begin
				if (points_due.size() == 0) begin
					$error("result transfer with no evaluate outstanding");
					errors++;
				end else begin
					want = points_due.pop_front();
					if (m_tdata[23:0] !== want.px) begin
						$error("pos_x expected %0d got %0d", want.px, $signed(m_tdata[23:0]));
						errors++;
					end
					if (m_tdata[47:24] !== want.py) begin
						$error("pos_y expected %0d got %0d", want.py, $signed(m_tdata[47:24]));
						errors++;
					end
					if (m_tdata[71:48] !== want.pz) begin
						$error("pos_z expected %0d got %0d", want.pz, $signed(m_tdata[71:48]));
						errors++;
					end
					if (m_tdata[77:72] !== want.row0) begin
						$error("span_row expected %0d got %0d", want.row0, m_tdata[77:72]);
						errors++;
					end
					if (m_tdata[83:78] !== want.col0) begin
						$error("span_col expected %0d got %0d", want.col0, m_tdata[83:78]);
						errors++;
					end
				end
			end
			pending <= points_due.size();
		end
	end
endmodule

>>> bench/tb_cubic_bspline_surface_eval.sv
// Testbench top for cubic_bspline_surface_eval: clock, reset, stimulus, verdict.
// Depends on cbs_pkg, the block's RTL and cbs_surface_checker.
`timescale 1ns / 100ps
module tb_cubic_bspline_surface_eval;
	import cbs_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [119:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [87:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = '0;
	logic [6:0] cfg_data = '0;
	int errors, pending;
	int results_seen = 0;
	bit burst = 1'b0;
	// grid entries written so far; evaluates only touch written entries
	bit written [4096];
	int rows_eff = 4;
	int cols_eff = 4;
	logic [6:0] rows_set [8] = '{7'd4, 7'd64, 7'd0, 7'd5, 7'd7, 7'd64, 7'd127, 7'd9};
	logic [6:0] cols_set [8] = '{7'd4, 7'd64, 7'd127, 7'd6, 7'd4, 7'd5, 7'd0, 7'd33};

	always #5 clk = ~clk;

	cubic_bspline_surface_eval DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	cbs_surface_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .errors(errors), .pending(pending)
	);

	function automatic int eff_size(logic [6:0] r);
		if (r < 4)
			return 4;
		if (r > 64)
			return 64;
		return int'(r);
	endfunction

	// first row or column of the window for one direction
	function automatic int span_of(logic [16:0] par, int size);
		int n, p, j;
		n = size - 3;
		p = (par > 17'd65536) ? 65536 : int'(par);
		j = (p * n) >>> 16;
		if (j >= n)
			j = n - 1;
		return j;
	endfunction

	// mostly near both ends so windows stay on a small part of the grid
	function automatic logic [16:0] rand_param(int size);
		int band;
		band = (3 * 65536) / (size - 3) + 1;
		if (band > 65536)
			band = 65536;
		case ($urandom_range(0, 7))
			0: return 17'd0;
			1: return 17'd65536;
			2: return 17'($urandom_range(65537, 131071));
			3, 4: return 17'($urandom_range(0, band));
			5, 6: return 17'($urandom_range(65536 - band, 65536));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic logic [23:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic send_item(req_t kind, logic [5:0] row, logic [5:0] col, logic [23:0] x,
			logic [23:0] y, logic [23:0] z, logic [16:0] u, logic [16:0] v);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {2'b00, v, u, z, y, x, col, row};
		s_tuser <= kind;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic put_point(logic [5:0] row, logic [5:0] col, logic [23:0] x, logic [23:0] y,
			logic [23:0] z);
		written[int'(row) * 64 + int'(col)] = 1'b1;
		send_item(REQ_WRITE, row, col, x, y, z, 17'($urandom), 17'($urandom));
	endtask

	task automatic eval_at(logic [16:0] u, logic [16:0] v);
		int ju, jv;
		ju = span_of(u, rows_eff);
		jv = span_of(v, cols_eff);
		for (int i = 0; i < 4; i++)
			for (int k = 0; k < 4; k++)
				if (!written[(ju + i) * 64 + jv + k])
					put_point(6'(ju + i), 6'(jv + k), rand_coord(), rand_coord(),
						rand_coord());
		send_item(REQ_EVAL, 6'($urandom), 6'($urandom), 24'($urandom), 24'($urandom),
			24'($urandom), u, v);
	endtask

	// sender pause until every result is back, with time for a trailing write
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_reg(reg_idx_t idx, logic [6:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_ROWS)
			rows_eff = eff_size(val);
		else
			cols_eff = eff_size(val);
	endtask

	// result side: random stalls, one long hold to back up the block
	initial begin
		int gap;
		@(posedge arst_n);
		m_tready <= 1'b1;
		forever begin
			if (results_seen == 20) begin
				m_tready <= 1'b0;
				repeat (600) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				gap = burst ? 0 : $urandom_range(0, 14);
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
					m_tready <= 1'b1;
				end
			end
			do @(posedge clk); while (!m_tvalid);
			results_seen++;
		end
	end

	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner window at the extremes: saturation both ways
		for (int i = 0; i < 16; i++)
			put_point(6'(i / 4), 6'(i % 4), 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
		eval_at(17'd0, 17'd0);
		eval_at(17'd32768, 17'd65536);
		eval_at(17'h1FFFF, 17'd12345);
		put_point(6'd63, 6'd63, 24'h800000, 24'h7FFFFF, 24'h000001);
		eval_at(17'd65536, 17'd0);
		eval_at(17'd1, 17'd65535);
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			set_reg(REG_ROWS, rows_set[ph]);
			set_reg(REG_COLS, cols_set[ph]);
			burst = (ph == 3);
			eval_at(17'd0, 17'd65536);
			eval_at(17'd65536, 17'h1FFFF);
			for (int n = 0; n < 45; n++) begin
				if ($urandom_range(0, 9) < 3)
					put_point(6'($urandom), 6'($urandom), rand_coord(), rand_coord(),
						rand_coord());
				else
					eval_at(rand_param(rows_eff), rand_param(cols_eff));
			end
			settle();
		end
		burst = 1'b0;

		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

>>> cubic_bspline_surface_eval.f
rtl/cbs_pkg.sv
rtl/cbs_ram.sv
rtl/cbs_weight.sv
rtl/cubic_bspline_surface_eval.sv
bench/cbs_surface_checker.sv
bench/tb_cubic_bspline_surface_eval.sv
